@@ rtl/efge_pkg.sv @@
// shared types and byte codes for the escaped frame gain extractor
// no dependencies; imported by efge_core, efge_out_buf, the top level and the testbench
`default_nettype none

package efge_pkg;

	// framing byte codes
	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_FLAG  = 8'h5e;
	localparam logic [7:0] ESC_ESC   = 8'h5d;

	// one result: three gains and a motor number
	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [7:0]  motor_number;
	} gain_res_t;

endpackage

`default_nettype wire

@@ rtl/efge_if.sv @@
// valid/ready channel interfaces for the escaped frame gain extractor
// efge_byte_if carries received bytes, efge_gain_if carries results
`default_nettype none

interface efge_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface efge_gain_if;
	logic        valid;
	logic        ready;
	logic [15:0] gain_p;
	logic [15:0] gain_i;
	logic [15:0] gain_d;
	logic [7:0]  motor_number;

	modport source (output valid, output gain_p, output gain_i, output gain_d,
		output motor_number, input ready);
	modport sink (input valid, input gain_p, input gain_i, input gain_d,
		input motor_number, output ready);
endinterface

`default_nettype wire

@@ rtl/efge_core.sv @@
// deframer state: flag/escape decoding, write position and frame store
// uses efge_pkg for byte codes and the result type
`default_nettype none

module efge_core
	import efge_pkg::*;
#(
	parameter int BUFFER_BYTES = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire logic  [7:0] rx_byte,
	output logic       res_valid,
	output gain_res_t  res
);

	localparam int PosW = $clog2(BUFFER_BYTES + 1);
	localparam logic [PosW:0] BufLimit = (PosW + 1)'(BUFFER_BYTES);

	logic            in_frame_q;
	logic            esc_q;
	logic [PosW-1:0] pos_q;
	logic [7:0]      store_q [BUFFER_BYTES];

	logic            in_frame_d;
	logic            esc_d;
	logic [PosW-1:0] base;
	logic [PosW:0]   base0;
	logic [PosW:0]   base1;
	logic            wr0;
	logic            wr1;
	logic [7:0]      d0;
	logic [7:0]      d1;
	logic            room0;
	logic            room1;
	logic            close;

	// decode the byte against the current framing state
	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		base       = pos_q;
		wr0        = 1'b0;
		wr1        = 1'b0;
		d0         = rx_byte;
		d1         = rx_byte;
		close      = 1'b0;
		if (!in_frame_q) begin
			// idle: only a flag opens a frame, stored at position zero
			if (rx_byte == FLAG_BYTE) begin
				in_frame_d = 1'b1;
				esc_d      = 1'b0;
				base       = '0;
				wr0        = 1'b1;
			end
		end else if (rx_byte == FLAG_BYTE) begin
			close      = 1'b1;
			in_frame_d = 1'b0;
			esc_d      = 1'b0;
		end else if (rx_byte == ESC_BYTE) begin
			esc_d = 1'b1;
		end else if (esc_q) begin
			esc_d = 1'b0;
			wr0   = 1'b1;
			case (rx_byte)
				ESC_FLAG: d0 = FLAG_BYTE;
				ESC_ESC:  d0 = ESC_BYTE;
				default: begin
					// invalid escape keeps the escape byte and the data byte
					d0  = ESC_BYTE;
					wr1 = 1'b1;
				end
			endcase
		end else begin
			wr0 = 1'b1;
		end
	end

	// room checks; a full store drops the byte
	assign base0 = {1'b0, base};
	assign base1 = base0 + (PosW + 1)'(1);
	assign room0 = wr0 && (base0 < BufLimit);
	assign room1 = wr1 && (base1 < BufLimit);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			pos_q      <= '0;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			if (close) begin
				pos_q <= '0;
			end else begin
				pos_q <= base + PosW'(room0) + PosW'(room1);
			end
		end
	end

	// frame store, up to two entries written per byte
	for (genvar i = 0; i < BUFFER_BYTES; i++) begin : g_store
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[i] <= '0;
			end else if (accept) begin
				if (room0 && (base0 == (PosW + 1)'(i))) begin
					store_q[i] <= d0;
				end else if (room1 && (base1 == (PosW + 1)'(i))) begin
					store_q[i] <= d1;
				end
			end
		end
	end

	// result fields read from the store as it stands
	assign res_valid        = accept && close;
	assign res.gain_p       = {store_q[2], store_q[1]};
	assign res.gain_i       = {store_q[4], store_q[3]};
	assign res.gain_d       = {store_q[6], store_q[5]};
	assign res.motor_number = store_q[7];

endmodule

`default_nettype wire

@@ rtl/efge_out_buf.sv @@
// output register with a skid stage for results
// uses efge_pkg for the result type
`default_nettype none

module efge_out_buf
	import efge_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  gain_res_t  push_data,
	output logic       can_push,
	output logic       out_valid,
	input  wire logic  out_ready,
	output gain_res_t  out_data
);

	logic      out_valid_q;
	gain_res_t out_q;
	logic      skid_valid_q;
	gain_res_t skid_q;
	logic      load;

	// the output register may load when empty or when its transfer completes
	assign load     = !out_valid_q || out_ready;
	assign can_push = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ rtl/escaped_frame_gain_extractor.sv @@
// top level of the escaped frame gain extractor
// depends on efge_pkg, efge_if, efge_core and efge_out_buf
//
// Byte-stuffed frame decoder. Received bytes arrive on rx (valid/ready,
// field rx_byte), one transfer per cycle while ready. A 0x7e flag opens
// a frame when idle; inside a frame 0x7d escapes the next byte (0x5e
// gives 0x7e, 0x5d gives 0x7d, a flag or 0x7d acts as usual, any other
// byte keeps both bytes). A closing 0x7e produces one result on gains:
// gain_p, gain_i, gain_d from store bytes 1..6 (little endian) and
// motor_number from byte 7. Short frames read stale store bytes.
// Bytes beyond BUFFER_BYTES are dropped. Throughput: one byte per cycle
// while rx is ready. A closing flag transfer registers its result.
// Stall: results sit in an output register backed by a one-entry skid stage;
// rx stays ready until both are full, i.e. a second result waits behind a
// stalled one.
// Reset: arst_n clears frame state, write position and the store to zero
// at once; there is no clearing pass.
`default_nettype none

module escaped_frame_gain_extractor
	import efge_pkg::*;
#(
	parameter int BUFFER_BYTES = 10
) (
	input wire logic    clk,
	input wire logic    arst_n,
	efge_byte_if.sink   rx,
	efge_gain_if.source gains
);

	logic      accept;
	logic      res_valid;
	gain_res_t res;
	logic      can_push;
	gain_res_t out_data;

	assign rx.ready = can_push;
	assign accept   = rx.valid && can_push;

	// framing and store
	efge_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx.rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	// result buffering
	efge_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.can_push (can_push),
		.out_valid(gains.valid),
		.out_ready(gains.ready),
		.out_data (out_data)
	);

	assign gains.gain_p       = out_data.gain_p;
	assign gains.gain_i       = out_data.gain_i;
	assign gains.gain_d       = out_data.gain_d;
	assign gains.motor_number = out_data.motor_number;

endmodule

`default_nettype wire

@@ tb/sv/escaped_frame_gain_extractor_tb.sv @@
// self-checking testbench for escaped_frame_gain_extractor: byte stream in, gain sets out
// depends on efge_pkg, efge_if and the escaped_frame_gain_extractor rtl
// a directed frame table runs first, then random frames checked against a built-in deframer

module escaped_frame_gain_extractor_tb
	import efge_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_BYTES = 10;
	localparam int FRAME_ITEMS = 500;
	localparam int TAIL_CYCLES = 4;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DIR_ROWS = 26;
	localparam gain_res_t NO_GAINS = '0;

	// one directed row: a byte and, where obvious, the gains its transfer closes with
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       typed;
		gain_res_t  gains;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// noise while idle, then an empty frame reading the cleared store
		'{8'h00, 1'b0, NO_GAINS},
		'{FLAG_BYTE, 1'b0, NO_GAINS},
		'{FLAG_BYTE, 1'b1, NO_GAINS},
		// all-ones payload, invalid escape at the last free slot, store full,
		// then a closing flag while an escape is pending
		'{FLAG_BYTE, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{ESC_BYTE, 1'b0, NO_GAINS},
		'{8'h00, 1'b0, NO_GAINS},
		'{8'hff, 1'b0, NO_GAINS},
		'{ESC_BYTE, 1'b0, NO_GAINS},
		'{FLAG_BYTE, 1'b1, '{gain_p: 16'hffff, gain_i: 16'hffff, gain_d: 16'hffff,
			motor_number: 8'hff}},
		// both valid escapes and a repeated escape in a short frame that reads stale bytes
		'{FLAG_BYTE, 1'b0, NO_GAINS},
		'{ESC_BYTE, 1'b0, NO_GAINS},
		'{ESC_FLAG, 1'b0, NO_GAINS},
		'{ESC_BYTE, 1'b0, NO_GAINS},
		'{ESC_ESC, 1'b0, NO_GAINS},
		'{ESC_BYTE, 1'b0, NO_GAINS},
		'{ESC_BYTE, 1'b0, NO_GAINS},
		'{8'h01, 1'b0, NO_GAINS},
		'{FLAG_BYTE, 1'b0, NO_GAINS}
	};

	logic clk;
	logic arst_n;

	efge_byte_if rx_if ();
	efge_gain_if gains_if ();

	escaped_frame_gain_extractor #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.gains(gains_if)
	);

	// deframer state mirrored by the testbench
	logic       frame_open;
	logic       escape_armed;
	int         fill_idx;
	logic [7:0] frame_mem [BUFFER_BYTES];

	gain_res_t gains_due [$];
	int        err_count;
	int        cycle_count;
	logic      tx_burst;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// store one byte unless the buffer is full
	function automatic void store_byte(input logic [7:0] b);
		if (fill_idx < BUFFER_BYTES) begin
			frame_mem[fill_idx] = b;
			fill_idx++;
		end
	endfunction

	// advance the deframer by one byte, returns 1 when a frame closes
	function automatic bit deframe_byte(input logic [7:0] b, output gain_res_t res);
		res = '0;
		if (!frame_open) begin
			if (b == FLAG_BYTE) begin
				frame_open = 1'b1;
				escape_armed = 1'b0;
				fill_idx = 0;
				store_byte(b);
			end
			return 1'b0;
		end
		if (b == FLAG_BYTE) begin
			res.gain_p = {frame_mem[2], frame_mem[1]};
			res.gain_i = {frame_mem[4], frame_mem[3]};
			res.gain_d = {frame_mem[6], frame_mem[5]};
			res.motor_number = frame_mem[7];
			frame_open = 1'b0;
			escape_armed = 1'b0;
			fill_idx = 0;
			return 1'b1;
		end
		if (b == ESC_BYTE) begin
			escape_armed = 1'b1;
		end else if (escape_armed) begin
			case (b)
				ESC_FLAG: store_byte(FLAG_BYTE);
				ESC_ESC:  store_byte(ESC_BYTE);
				default: begin
					store_byte(ESC_BYTE);
					store_byte(b);
				end
			endcase
			escape_armed = 1'b0;
		end else begin
			store_byte(b);
		end
		return 1'b0;
	endfunction

	// send one byte after a random gap, predict once the transfer happens
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input gain_res_t typed_gains = '0);
		int        gap;
		gain_res_t res;

		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		if (deframe_byte(b, res))
			gains_due.push_back(typed ? typed_gains : res);
	endtask

	// hold the sender off until every pending gain set has come out
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (gains_due.size() != 0);
	endtask

	// random special byte: flag, escape or an escape code
	function automatic logic [7:0] special_byte();
		case ($urandom_range(0, 3))
			0:       return FLAG_BYTE;
			1:       return ESC_BYTE;
			2:       return ESC_FLAG;
			default: return ESC_ESC;
		endcase
	endfunction

	// one mostly well-formed frame with random content, some noise and broken escapes
	task automatic send_frame(inout int count);
		int         len;
		int         noise;
		logic [7:0] d;

		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (noise) begin
			d = 8'($urandom_range(0, 255));
			if (d == FLAG_BYTE)
				d = ESC_BYTE;
			send_byte(d);
		end
		send_byte(FLAG_BYTE);
		count++;
		case ($urandom_range(0, 7))
			0:       len = $urandom_range(0, 12);
			1:       len = $urandom_range(8, 10);
			default: len = 7;
		endcase
		repeat (len) begin
			d = ($urandom_range(0, 5) == 0) ? special_byte() : 8'($urandom_range(0, 255));
			if ($urandom_range(0, 11) == 0) begin
				// raw escape ahead of any byte
				send_byte(ESC_BYTE);
				send_byte(d);
				count += 2;
			end else if (d == FLAG_BYTE) begin
				send_byte(ESC_BYTE);
				send_byte(ESC_FLAG);
				count += 2;
			end else if (d == ESC_BYTE) begin
				send_byte(ESC_BYTE);
				send_byte(ESC_ESC);
				count += 2;
			end else begin
				send_byte(d);
				count++;
			end
		end
		if ($urandom_range(0, 15) == 0) begin
			send_byte(ESC_BYTE);
			count++;
		end
		send_byte(FLAG_BYTE);
		count++;
	endtask

	// result side: random stalls, each transfer checked against the oldest prediction
	initial begin
		int        stall;
		logic      rx_burst;
		gain_res_t want;

		rx_burst = 1'b0;
		gains_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 7) == 0)
				rx_burst = ~rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				gains_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			gains_if.ready <= 1'b1;
			do @(posedge clk); while (!gains_if.valid);
			if (gains_due.size() == 0) begin
				$error("gain transfer with nothing pending");
				err_count++;
			end else begin
				want = gains_due.pop_front();
				if (gains_if.gain_p !== want.gain_p) begin
					$error("gain_p: expected %h, got %h", want.gain_p, gains_if.gain_p);
					err_count++;
				end
				if (gains_if.gain_i !== want.gain_i) begin
					$error("gain_i: expected %h, got %h", want.gain_i, gains_if.gain_i);
					err_count++;
				end
				if (gains_if.gain_d !== want.gain_d) begin
					$error("gain_d: expected %h, got %h", want.gain_d, gains_if.gain_d);
					err_count++;
				end
				if (gains_if.motor_number !== want.motor_number) begin
					$error("motor_number: expected %h, got %h", want.motor_number,
						gains_if.motor_number);
					err_count++;
				end
			end
		end
	end

	// byte side: reset, directed table, random frames, drain
	initial begin
		int frame_items;
		int n_frames;

		err_count = 0;
		tx_burst = 1'b0;
		frame_open = 1'b0;
		escape_armed = 1'b0;
		fill_idx = 0;
		for (int i = 0; i < BUFFER_BYTES; i++)
			frame_mem[i] = '0;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(DIR_TABLE[i].rx_byte, DIR_TABLE[i].typed, DIR_TABLE[i].gains);
		wait_drained();

		// random frames, with bursts and a full drain every so often
		frame_items = 0;
		n_frames = 0;
		while (frame_items < FRAME_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			send_frame(frame_items);
			n_frames++;
			if (n_frames % 16 == 0)
				wait_drained();
		end
		tx_burst = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
rtl/efge_pkg.sv
rtl/efge_if.sv
rtl/efge_core.sv
rtl/efge_out_buf.sv
rtl/escaped_frame_gain_extractor.sv
tb/sv/escaped_frame_gain_extractor_tb.sv
